@@ src/csa_pkg.sv @@
package csa_pkg;

	localparam int MAX_DIM_DEF = 16;
	localparam int MAX_CLASSES_DEF = 8;

	localparam int FEAT_W = 16;
	localparam int SUM_W = 64;
	localparam int CNT_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	// Widths of s_tdata and m_tdata (command stays in s_tuser)
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 96;

	typedef enum logic [0:0] {
		CMD_ADD  = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		RK_SCATTER = 2'd0,
		RK_CSUM    = 2'd1,
		RK_GSUM    = 2'd2,
		RK_CCOUNT  = 2'd3
	} read_kind_t;

	typedef enum logic [1:0] {
		ST_BUFFERED  = 2'd0,
		ST_ACCUM     = 2'd1,
		ST_BAD_CLASS = 2'd2,
		ST_READ      = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_DIMS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CLASSES = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_VEC_RD,
		S_VEC_ADD,
		S_MAC_RD,
		S_MAC_MUL,
		S_MAC_ADD,
		S_RD_WAIT,
		S_RD_DATA,
		S_OUT
	} state_t;

endpackage

@@ src/csa_ram.sv @@
module csa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/class_scatter_accumulator.sv @@
// Class scatter accumulator.
// s_* carries one request per item: an element to add (command in s_tuser = 0)
// or a read of a stored sum or count (command = 1). m_* returns one result per
// request: status, saturating vector total and 64-bit read data.
// An element that does not complete a vector (or a bad class) goes straight
// to the result state. For the final element of a vector the sequencer, per
// row i, adds x[i] into the 64-bit class and global sums, then steps one
// shared 16x16 multiplier over the upper triangle j >= i, with one
// read-modify-write of the scatter store per product. A read passes through
// S_RD_WAIT and S_RD_DATA to the result. One request is in work at a time;
// s_tready is low meanwhile and while a result waits on a stalled m_tready.
// After reset the block sweeps the three sum stores to zero, one address per
// cycle, with s_tready low; configuration writes are taken during the sweep.
// dims_in_use resets to 16, classes_in_use to 8.
// Configuration (cfg_we/cfg_index/cfg_data) must be written while idle.
module class_scatter_accumulator #(
	parameter int MAX_DIM = csa_pkg::MAX_DIM_DEF,
	parameter int MAX_CLASSES = csa_pkg::MAX_CLASSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// feature_value[15:0], class_index[19:16], read_kind[21:20],
	// read_row[25:22], read_col[29:26], zero fill
	input  logic [csa_pkg::S_TDATA_W-1:0]   s_tdata,
	// command
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// total_vectors[31:0], read_data[95:32]
	output logic [csa_pkg::M_TDATA_W-1:0]   m_tdata,
	// status
	output logic [1:0]                      m_tuser,
	input  logic                            cfg_we,
	input  logic [csa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [csa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int DW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int PW = $clog2(MAX_DIM + 1);
	localparam int CSD = MAX_CLASSES * MAX_DIM;
	localparam int SCD = CSD * MAX_DIM;
	localparam int CSA = $clog2(CSD) > 0 ? $clog2(CSD) : 1;
	localparam int SCA = $clog2(SCD) > 0 ? $clog2(SCD) : 1;
	localparam int SUM_W = csa_pkg::SUM_W;
	localparam int CNT_W = csa_pkg::CNT_W;

	csa_pkg::state_t state_q, state_d;

	logic [4:0] dims_q;
	logic [3:0] classes_q;
	logic [PW-1:0] pos_q;
	logic [SCA-1:0] clr_q;
	logic [DW-1:0] i_q, j_q;
	logic [CW-1:0] k_q;
	logic [PW-1:0] d_q;
	logic [1:0] status_q;
	logic [CNT_W-1:0] total_q;
	logic [SUM_W-1:0] data_q;
	logic [CNT_W-1:0] ccount_q [MAX_CLASSES];
	logic signed [csa_pkg::FEAT_W-1:0] vi_q;
	logic signed [2*csa_pkg::FEAT_W-1:0] prod_q;
	logic read_zero_q;
	logic [1:0] kind_q;

	// input fields
	logic signed [15:0] f_value;
	logic [3:0] f_class, f_row, f_col;
	logic [1:0] f_kind;
	assign f_value = s_tdata[15:0];
	assign f_class = s_tdata[19:16];
	assign f_kind = s_tdata[21:20];
	assign f_row = s_tdata[25:22];
	assign f_col = s_tdata[29:26];

	logic [PW-1:0] eff_dims;
	logic [4:0] eff_cls;
	always_comb begin
		if (dims_q == 5'd0) eff_dims = PW'(1);
		else if (32'(dims_q) > MAX_DIM) eff_dims = PW'(MAX_DIM);
		else eff_dims = PW'(dims_q);
		if (classes_q == 4'd0) eff_cls = 5'd1;
		else if (32'(classes_q) > MAX_CLASSES) eff_cls = 5'(MAX_CLASSES);
		else eff_cls = {1'b0, classes_q};
	end

	// vector buffer memory
	logic vb_we;
	logic [DW-1:0] vb_wa, vb_ra;
	logic [15:0] vb_rd;
	csa_ram #(.WIDTH(16), .DEPTH(MAX_DIM)) u_vbuf (
		.clk(clk), .we(vb_we), .waddr(vb_wa), .wdata(f_value), .raddr(vb_ra), .rdata(vb_rd)
	);

	logic sc_we, cs_we, gs_we;
	logic [SCA-1:0] sc_wa, sc_ra;
	logic [CSA-1:0] cs_wa, cs_ra;
	logic [DW-1:0] gs_wa, gs_ra;
	logic [SUM_W-1:0] sc_wd, cs_wd, gs_wd, sc_rd, cs_rd, gs_rd;
	csa_ram #(.WIDTH(SUM_W), .DEPTH(SCD)) u_scatter (
		.clk(clk), .we(sc_we), .waddr(sc_wa), .wdata(sc_wd), .raddr(sc_ra), .rdata(sc_rd)
	);
	csa_ram #(.WIDTH(SUM_W), .DEPTH(CSD)) u_csum (
		.clk(clk), .we(cs_we), .waddr(cs_wa), .wdata(cs_wd), .raddr(cs_ra), .rdata(cs_rd)
	);
	csa_ram #(.WIDTH(SUM_W), .DEPTH(MAX_DIM)) u_gsum (
		.clk(clk), .we(gs_we), .waddr(gs_wa), .wdata(gs_wd), .raddr(gs_ra), .rdata(gs_rd)
	);

	logic accept;
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == csa_pkg::S_IDLE);
	assign m_tvalid = (state_q == csa_pkg::S_OUT);
	assign m_tdata = {data_q, total_q};
	assign m_tuser = status_q;

	// add-element decode
	logic [PW-1:0] pos_clip;
	logic last_elem;
	assign pos_clip = (pos_q >= eff_dims) ? eff_dims - PW'(1) : pos_q;
	assign last_elem = (pos_clip + PW'(1)) >= eff_dims;

	logic [SCA-1:0] sc_idx;
	logic [CSA-1:0] cs_idx;
	assign sc_idx = SCA'((32'(k_q) * MAX_DIM + 32'(i_q)) * MAX_DIM + 32'(j_q));
	assign cs_idx = CSA'(32'(k_q) * MAX_DIM + 32'(i_q));

	logic clr_last;
	assign clr_last = (32'(clr_q) == SCD - 1);
	logic i_last, j_last;
	assign i_last = (32'(i_q) + 1 >= 32'(d_q));
	assign j_last = (32'(j_q) + 1 >= 32'(d_q));

	always_comb begin
		state_d = state_q;
		vb_we = 1'b0;
		vb_wa = pos_clip[DW-1:0];
		vb_ra = (state_q == csa_pkg::S_MAC_RD) ? j_q : i_q;
		sc_we = 1'b0; cs_we = 1'b0; gs_we = 1'b0;
		sc_wa = sc_idx; cs_wa = cs_idx; gs_wa = i_q;
		sc_ra = sc_idx; cs_ra = cs_idx; gs_ra = i_q;
		sc_wd = sc_rd + SUM_W'(prod_q);
		cs_wd = cs_rd + SUM_W'(signed'(vb_rd));
		gs_wd = gs_rd + SUM_W'(signed'(vb_rd));
		unique case (state_q)
			csa_pkg::S_CLEAR: begin
				sc_we = 1'b1; sc_wa = clr_q; sc_wd = '0;
				cs_we = 1'b1; cs_wa = CSA'(clr_q); cs_wd = '0;
				gs_we = 1'b1; gs_wa = DW'(clr_q); gs_wd = '0;
				if (clr_last) state_d = csa_pkg::S_IDLE;
			end
			csa_pkg::S_IDLE: begin
				if (accept) begin
					if (s_tuser == csa_pkg::CMD_READ) begin
						state_d = csa_pkg::S_RD_WAIT;
						sc_ra = SCA'((32'(CW'(f_class)) * MAX_DIM + 32'(DW'(f_row)))
							* MAX_DIM + 32'(DW'(f_col)));
						cs_ra = CSA'(32'(CW'(f_class)) * MAX_DIM + 32'(DW'(f_row)));
						gs_ra = DW'(f_row);
					end else begin
						vb_we = 1'b1;
						if (last_elem && ({1'b0, f_class} < eff_cls)) begin
							state_d = csa_pkg::S_VEC_RD;
						end else begin
							state_d = csa_pkg::S_OUT;
						end
					end
				end
			end
			// read x[i] and sums for row i
			csa_pkg::S_VEC_RD: state_d = csa_pkg::S_VEC_ADD;
			csa_pkg::S_VEC_ADD: begin
				cs_we = 1'b1; gs_we = 1'b1;
				state_d = csa_pkg::S_MAC_RD;
			end
			// fetch x[j] and scatter[k][i][j]
			csa_pkg::S_MAC_RD: state_d = csa_pkg::S_MAC_MUL;
			csa_pkg::S_MAC_MUL: state_d = csa_pkg::S_MAC_ADD;
			csa_pkg::S_MAC_ADD: begin
				sc_we = 1'b1;
				if (!j_last) state_d = csa_pkg::S_MAC_RD;
				else if (!i_last) state_d = csa_pkg::S_VEC_RD;
				else state_d = csa_pkg::S_OUT;
			end
			csa_pkg::S_RD_WAIT: state_d = csa_pkg::S_RD_DATA;
			csa_pkg::S_RD_DATA: state_d = csa_pkg::S_OUT;
			csa_pkg::S_OUT: if (m_tready) state_d = csa_pkg::S_IDLE;
			default: state_d = csa_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 5'd16;
			classes_q <= 4'd8;
			pos_q <= '0;
			clr_q <= '0;
			total_q <= '0;
			status_q <= csa_pkg::ST_BUFFERED;
			for (int c = 0; c < MAX_CLASSES; c++) ccount_q[c] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == csa_pkg::REG_DIMS) dims_q <= cfg_data;
				else if (cfg_index == csa_pkg::REG_CLASSES) classes_q <= cfg_data[3:0];
			end
			if (state_q == csa_pkg::S_CLEAR) clr_q <= clr_q + SCA'(1);
			if (accept && s_tuser == csa_pkg::CMD_ADD) begin
				if (last_elem) begin
					pos_q <= '0;
					if ({1'b0, f_class} < eff_cls) begin
						status_q <= csa_pkg::ST_ACCUM;
					end else begin
						status_q <= csa_pkg::ST_BAD_CLASS;
					end
				end else begin
					pos_q <= pos_clip + PW'(1);
					status_q <= csa_pkg::ST_BUFFERED;
				end
			end else if (accept) begin
				status_q <= csa_pkg::ST_READ;
			end
			if (state_q == csa_pkg::S_MAC_ADD && j_last && i_last) begin
				if (~&total_q) total_q <= total_q + CNT_W'(1);
				if (~&ccount_q[k_q]) ccount_q[k_q] <= ccount_q[k_q] + CNT_W'(1);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == csa_pkg::S_IDLE && accept) begin
			k_q <= CW'(f_class);
			d_q <= eff_dims;
			// a read holds its row and column so the store addresses stay put
			i_q <= (s_tuser == csa_pkg::CMD_READ) ? DW'(f_row) : '0;
			j_q <= (s_tuser == csa_pkg::CMD_READ) ? DW'(f_col) : '0;
			kind_q <= f_kind;
			data_q <= '0;
			read_zero_q <= (f_kind == csa_pkg::RK_GSUM) ? (32'(f_row) >= MAX_DIM) :
				((32'(f_class) >= MAX_CLASSES) ||
				((f_kind != csa_pkg::RK_CCOUNT) && (32'(f_row) >= MAX_DIM)) ||
				((f_kind == csa_pkg::RK_SCATTER) && (32'(f_col) >= MAX_DIM)));
		end
		if (state_q == csa_pkg::S_VEC_ADD) begin
			vi_q <= vb_rd;
			j_q <= i_q;
		end
		if (state_q == csa_pkg::S_MAC_MUL) prod_q <= vi_q * signed'(vb_rd);
		if (state_q == csa_pkg::S_MAC_ADD) begin
			if (!j_last) j_q <= j_q + DW'(1);
			else if (!i_last) i_q <= i_q + DW'(1);
		end
		if (state_q == csa_pkg::S_RD_DATA) begin
			if (read_zero_q) data_q <= '0;
			else begin
				case (kind_q)
					csa_pkg::RK_SCATTER: data_q <= sc_rd;
					csa_pkg::RK_CSUM: data_q <= cs_rd;
					csa_pkg::RK_GSUM: data_q <= gs_rd;
					default: data_q <= SUM_W'(ccount_q[k_q]);
				endcase
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_total_mono: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != csa_pkg::S_CLEAR |=> total_q >= $past(total_q))
		else $error("total count went down");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("ready while result pending");
	a_mac_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == csa_pkg::S_MAC_ADD |-> j_q >= i_q)
		else $error("lower triangle update");
`endif

endmodule

@@ sim/testbench.sv @@
module testbench;

	typedef struct {
		csa_pkg::cmd_t       cmd;
		shortint             feat;
		logic [3:0]          cls;
		csa_pkg::read_kind_t kind;
		logic [3:0]          row;
		logic [3:0]          col;
	} request_t;

	typedef struct {
		csa_pkg::status_t status;
		logic [31:0]      total;
		logic [63:0]      data;
	} result_t;

	typedef struct {
		request_t         rq;
		bit               typed;
		csa_pkg::status_t status;
		logic [63:0]      data;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [csa_pkg::S_TDATA_W-1:0] s_tdata;
	logic s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [csa_pkg::M_TDATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we;
	logic [csa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [csa_pkg::CFG_DATA_W-1:0] cfg_data;

	class_scatter_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow state of the accumulator
	logic [4:0]  dims_reg;
	logic [3:0]  classes_reg;
	shortint     vec_buf [16];
	int unsigned vec_pos;
	logic [63:0] scatter_sum [8][16][16];
	logic [63:0] class_sum [8][16];
	logic [63:0] global_sum [16];
	logic [31:0] class_count [8];
	logic [31:0] vector_count;

	result_t     pending_results [$];
	int          error_count;
	bit          calm;
	bit          hold_req;

	function automatic result_t accumulate_request(request_t rq);
		result_t res;
		int unsigned d, q, p;
		logic [63:0] prod;
		d = (dims_reg == 0) ? 1 : (dims_reg > 16) ? 16 : dims_reg;
		q = (classes_reg == 0) ? 1 : (classes_reg > 8) ? 8 : classes_reg;
		res.data = '0;
		if (rq.cmd == csa_pkg::CMD_READ) begin
			res.status = csa_pkg::ST_READ;
			case (rq.kind)
				csa_pkg::RK_SCATTER:
					if (rq.cls < 8) res.data = scatter_sum[rq.cls][rq.row][rq.col];
				csa_pkg::RK_CSUM:    if (rq.cls < 8) res.data = class_sum[rq.cls][rq.row];
				csa_pkg::RK_GSUM:    res.data = global_sum[rq.row];
				default:    if (rq.cls < 8) res.data = {32'd0, class_count[rq.cls]};
			endcase
		end else begin
			p = (vec_pos >= d) ? d - 1 : vec_pos;
			vec_buf[p] = rq.feat;
			if (p + 1 >= d) begin
				vec_pos = 0;
				if (rq.cls < q) begin
					for (int i = 0; i < d; i++) begin
						global_sum[i] += 64'(longint'(vec_buf[i]));
						class_sum[rq.cls][i] += 64'(longint'(vec_buf[i]));
						for (int j = i; j < d; j++) begin
							prod = 64'(longint'(vec_buf[i]) * longint'(vec_buf[j]));
							scatter_sum[rq.cls][i][j] += prod;
						end
					end
					if (class_count[rq.cls] != '1) class_count[rq.cls]++;
					if (vector_count != '1) vector_count++;
					res.status = csa_pkg::ST_ACCUM;
				end else begin
					res.status = csa_pkg::ST_BAD_CLASS;
				end
			end else begin
				vec_pos = p + 1;
				res.status = csa_pkg::ST_BUFFERED;
			end
		end
		res.total = vector_count;
		return res;
	endfunction

	function automatic plan_row_t plan_row(csa_pkg::cmd_t c, shortint f, int k,
			csa_pkg::read_kind_t rk, int r, int cl, bit typed, csa_pkg::status_t st,
			longint dat);
		plan_row_t pr;
		pr.rq = '{c, f, 4'(k), rk, 4'(r), 4'(cl)};
		pr.typed = typed;
		pr.status = st;
		pr.data = 64'(dat);
		return pr;
	endfunction

	task automatic send_request(request_t rq, bit typed, csa_pkg::status_t st,
			logic [63:0] dat);
		int gap;
		result_t res;
		gap = calm ? 0 : $urandom_range(19);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rq.cmd;
		s_tdata <= {2'b00, rq.col, rq.row, rq.kind, rq.cls, rq.feat};
		do @(posedge clk); while (!s_tready);
		res = accumulate_request(rq);
		if (typed) begin
			res.status = st;
			res.data = dat;
		end
		pending_results.push_back(res);
	endtask

	task automatic write_register(logic [csa_pkg::CFG_IDX_W-1:0] idx, logic [4:0] val);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == csa_pkg::REG_DIMS) dims_reg = val;
		else classes_reg = val[3:0];
	endtask

	function automatic shortint pick_feature();
		case ($urandom_range(5))
			0: return shortint'(16'h7fff);
			1: return shortint'(16'h8000);
			2: return shortint'($urandom_range(7)) - 3;
			default: return shortint'($urandom);
		endcase
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#18_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request, and the checker
	initial begin
		result_t want;
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				stall = calm ? 0 : $urandom_range(19);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_results.size() == 0) begin
				$display("%0t: result with none expected: status %0d total %0d data %0h",
					$time, m_tuser, m_tdata[31:0], m_tdata[95:32]);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser != want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
					error_count++;
				end
				if (m_tdata[31:0] != want.total) begin
					$display("%0t: total expected %0d actual %0d", $time, want.total,
						m_tdata[31:0]);
					error_count++;
				end
				if (m_tdata[95:32] != want.data) begin
					$display("%0t: data expected %0h actual %0h", $time, want.data,
						m_tdata[95:32]);
					error_count++;
				end
			end
		end
	end

	initial begin
		plan_row_t plan [$];
		request_t rq;
		logic [4:0] dims_pick [6];
		logic [4:0] class_pick [6];
		int n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		dims_reg = 5'd16;
		classes_reg = 4'd8;
		vec_pos = 0;
		vector_count = '0;
		foreach (vec_buf[i]) vec_buf[i] = 0;
		foreach (global_sum[i]) global_sum[i] = '0;
		foreach (class_count[k]) class_count[k] = '0;
		foreach (class_sum[k, i]) class_sum[k][i] = '0;
		foreach (scatter_sum[k, i, j]) scatter_sum[k][i][j] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// store is clear after reset, then one two-element vector with extremes
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 7, csa_pkg::RK_SCATTER, 15, 15, 1,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_GSUM, 0, 0, 1,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_ADD, 32767, 0, csa_pkg::RK_SCATTER, 0, 0, 1,
			csa_pkg::ST_BUFFERED, 0));
		plan.push_back(plan_row(csa_pkg::CMD_ADD, -32768, 0, csa_pkg::RK_SCATTER, 0, 0, 1,
			csa_pkg::ST_ACCUM, 0));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_SCATTER, 0, 0, 1,
			csa_pkg::ST_READ, 1073676289));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_SCATTER, 0, 1, 1,
			csa_pkg::ST_READ, -1073709056));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_SCATTER, 1, 1, 1,
			csa_pkg::ST_READ, 1073741824));
		// lower triangle stays zero
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_SCATTER, 1, 0, 1,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_CSUM, 1, 0, 1,
			csa_pkg::ST_READ, -32768));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_GSUM, 0, 0, 1,
			csa_pkg::ST_READ, 32767));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 0, csa_pkg::RK_CCOUNT, 0, 0, 1,
			csa_pkg::ST_READ, 1));
		// class beyond the register: discard
		plan.push_back(plan_row(csa_pkg::CMD_ADD, 5, 0, csa_pkg::RK_SCATTER, 0, 0, 1,
			csa_pkg::ST_BUFFERED, 0));
		plan.push_back(plan_row(csa_pkg::CMD_ADD, 1, 3, csa_pkg::RK_SCATTER, 0, 0, 1,
			csa_pkg::ST_BAD_CLASS, 0));
		plan.push_back(plan_row(csa_pkg::CMD_ADD, -1, 0, csa_pkg::RK_SCATTER, 0, 0, 0,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_ADD, -7, 1, csa_pkg::RK_SCATTER, 0, 0, 0,
			csa_pkg::ST_READ, 0));
		// class beyond the stores reads zero; within stores reads the value
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 15, csa_pkg::RK_CSUM, 0, 0, 1,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 15, csa_pkg::RK_CCOUNT, 0, 0, 1,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 1, csa_pkg::RK_SCATTER, 0, 1, 0,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 1, csa_pkg::RK_CCOUNT, 0, 0, 0,
			csa_pkg::ST_READ, 0));
		plan.push_back(plan_row(csa_pkg::CMD_READ, 0, 5, csa_pkg::RK_CSUM, 15, 0, 0,
			csa_pkg::ST_READ, 0));

		write_register(csa_pkg::REG_DIMS, 5'd2);
		write_register(csa_pkg::REG_CLASSES, 5'd2);
		foreach (plan[i]) send_request(plan[i].rq, plan[i].typed, plan[i].status, plan[i].data);

		dims_pick = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd5};
		class_pick = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd6};
		for (int ph = 0; ph < 10; ph++) begin
			// dims may drop with a vector half gathered
			write_register(csa_pkg::REG_DIMS,
				(ph < 6) ? dims_pick[ph] : 5'($urandom_range(1, 6)));
			write_register(csa_pkg::REG_CLASSES,
				(ph < 6) ? class_pick[ph] : 5'($urandom_range(15)));
			calm = (ph % 3 == 1);
			n = (ph == 1 || ph == 3) ? 30 : 55;
			for (int i = 0; i < n; i++) begin
				if (ph == 4 && i == 5) hold_req = 1'b1;
				rq.cmd = ($urandom_range(99) < 20) ? csa_pkg::CMD_READ : csa_pkg::CMD_ADD;
				rq.feat = pick_feature();
				rq.cls = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(7));
				rq.kind = csa_pkg::read_kind_t'($urandom_range(3));
				rq.row = 4'($urandom);
				rq.col = 4'($urandom);
				send_request(rq, 1'b0, csa_pkg::ST_READ, '0);
			end
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
